[design/velocity_form_pid_macros.svh]
// ============================================================================
// Assertion macros for the velocity-form PID block
// Clocked assertion wrappers used by the checker file.
// ============================================================================
`ifndef VELOCITY_FORM_PID_MACROS_SVH
`define VELOCITY_FORM_PID_MACROS_SVH

// Checked only outside reset
`define VFP_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included
`define VFP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[design/vfp_pkg.sv]
// ============================================================================
// vfp_pkg
// Shared constants, register indexes and sequencer control types.
// ============================================================================
`default_nettype none

package vfp_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_PROP      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_INTEGRAL  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_DERIV     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_STEP      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_TIME_STEP  = 3'd5;

    // Operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        OP_KD_INVDT,
        OP_KI_DT,
        OP_CA_E0,
        OP_CB_E1,
        OP_CC_E2
    } mul_sel_t;

    typedef struct packed {
        logic     mul_en;     // load a new product
        mul_sel_t mul_sel;
        logic     ld_kdi;     // capture kd*inv_dt
        logic     ld_coef;    // build and clip a, b, c
        logic     acc_first;  // start the delta sum
        logic     acc_add;    // add the next term
        logic     finish;     // close the item, update state and output
    } seq_ctrl_t;

endpackage

`default_nettype wire

[design/vfp_cfg_regs.sv]
// ============================================================================
// vfp_cfg_regs
// Configuration register file: setpoint, gains and time-step registers.
// ============================================================================
`default_nettype none

module vfp_cfg_regs
    import vfp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [DATA_WIDTH-1:0]        cfg_wdata,
    output logic signed [DATA_WIDTH-1:0]      setpoint,
    output logic signed [DATA_WIDTH-1:0]      gain_proportional,
    output logic signed [DATA_WIDTH-1:0]      gain_integral,
    output logic signed [DATA_WIDTH-1:0]      gain_derivative,
    output logic [DATA_WIDTH-2:0]             time_step,
    output logic [DATA_WIDTH-2:0]             inverse_time_step
);

    // 1.0 in the fixed-point format
    localparam logic [DATA_WIDTH-2:0] ONE_FX = (DATA_WIDTH-1)'(1) << FRAC_BITS;

    logic signed [DATA_WIDTH-1:0] setpoint_reg, kp_reg, ki_reg, kd_reg;
    logic [DATA_WIDTH-2:0]        dt_reg, inv_dt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg <= '0;
            kp_reg       <= '0;
            ki_reg       <= '0;
            kd_reg       <= '0;
            dt_reg       <= ONE_FX;
            inv_dt_reg   <= ONE_FX;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SETPOINT:      setpoint_reg <= signed'(cfg_wdata);
                REG_GAIN_PROP:     kp_reg       <= signed'(cfg_wdata);
                REG_GAIN_INTEGRAL: ki_reg       <= signed'(cfg_wdata);
                REG_GAIN_DERIV:    kd_reg       <= signed'(cfg_wdata);
                REG_TIME_STEP:     dt_reg       <= cfg_wdata[DATA_WIDTH-2:0];
                REG_INV_TIME_STEP: inv_dt_reg   <= cfg_wdata[DATA_WIDTH-2:0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    assign setpoint          = setpoint_reg;
    assign gain_proportional = kp_reg;
    assign gain_integral     = ki_reg;
    assign gain_derivative   = kd_reg;
    assign time_step         = dt_reg;
    assign inverse_time_step = inv_dt_reg;

endmodule

`default_nettype wire

[design/vfp_mul.sv]
// ============================================================================
// vfp_mul
// Shared signed multiplier with a registered full-width product.
// ============================================================================
`default_nettype none

module vfp_mul
    import vfp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           mul_en,
    input  wire logic signed [DATA_WIDTH-1:0]   mul_a,
    input  wire logic signed [DATA_WIDTH-1:0]   mul_b,
    output logic signed [2*DATA_WIDTH-1:0]      prod
);

    logic signed [2*DATA_WIDTH-1:0] prod_reg;

    // hold the product while the sequencer consumes it
    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

[design/vfp_seq.sv]
// ============================================================================
// vfp_seq
// Step sequencer that schedules the five products on the shared multiplier.
// ============================================================================
`default_nettype none

module vfp_seq
    import vfp_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  start,
    input  wire logic  out_free,
    output logic       ready,
    output seq_ctrl_t  ctrl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KD,
        ST_KI,
        ST_COEF,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_SUM
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_KD;
            ST_KD:   state_next = ST_KI;
            ST_KI:   state_next = ST_COEF;
            ST_COEF: state_next = ST_M0;
            ST_M0:   state_next = ST_M1;
            ST_M1:   state_next = ST_M2;
            ST_M2:   state_next = ST_SUM;
            ST_SUM:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        ctrl = '0;
        ctrl.mul_sel = OP_KD_INVDT;
        unique case (state_reg)
            ST_KD: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = OP_KD_INVDT;
            end
            ST_KI: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = OP_KI_DT;
                ctrl.ld_kdi  = 1'b1;
            end
            ST_COEF: begin
                ctrl.ld_coef = 1'b1;
            end
            ST_M0: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = OP_CA_E0;
            end
            ST_M1: begin
                ctrl.mul_en    = 1'b1;
                ctrl.mul_sel   = OP_CB_E1;
                ctrl.acc_first = 1'b1;
            end
            ST_M2: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = OP_CC_E2;
                ctrl.acc_add = 1'b1;
            end
            ST_SUM: begin
                ctrl.finish = out_free;
            end
            default: begin
                // idle: nothing to drive
            end
        endcase
    end

    assign ready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

[design/velocity_form_pid.sv]
// ============================================================================
// velocity_form_pid
// Incremental (velocity-form) PID controller in signed fixed point.
// ============================================================================
// Usage:
//   Write setpoint, gains and time-step registers over the cfg_* port while
//   the block is idle. Each beat on s_* carries one measured sample; each
//   beat on m_* carries the updated control value (tdata) and a flag
//   (tuser) that is set when the error or the control value was clipped.
//   Every input beat yields exactly one output beat.
// Sequencing:
//   After a sample is accepted, five products (kd*inv_dt, ki*dt, a*e0, b*e1,
//   c*e2) go through the single shared multiplier one after another, plus a
//   step that builds the coefficients and a final step that adds the last
//   term and clips; the result then shows on m_tvalid. The next sample is
//   taken only once the block is back in idle, never while one is in work.
// Reset:
//   aresetn (synchronous, active low) clears the control value and the
//   error history, zeroes setpoint and gains, and sets both time-step
//   registers to 1.0. No result is pending after reset.
// Receiver stall:
//   The result sits in an output register. A new sample is still taken
//   while it waits; the block then holds in its final step until the
//   output register frees up, and s_tready stays low meanwhile.
// ============================================================================
`default_nettype none

module velocity_form_pid
    import vfp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration write port
    input  wire logic                          cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [DATA_WIDTH-1:0]         cfg_wdata,
    // sample stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [((DATA_WIDTH+7)/8)*8-1:0] s_tdata,  // [DATA_WIDTH-1:0] measured
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]    m_tdata,    // [DATA_WIDTH-1:0] control_out
    output logic                               m_tuser     // [0] saturated
);

    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
    // width of a product after the fractional shift
    localparam int PW = 2 * DATA_WIDTH - FRAC_BITS;
    // working width for coefficient and delta sums
    localparam int CW = ((PW > DATA_WIDTH) ? PW : DATA_WIDTH) + 2;
    localparam int EW = DATA_WIDTH + 1;

    localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // ---------------------------------------------------------------- config
    logic signed [DATA_WIDTH-1:0] setpoint, kp, ki, kd;
    logic [DATA_WIDTH-2:0]        dt, inv_dt;

    vfp_cfg_regs #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_cfg_regs (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .setpoint          (setpoint),
        .gain_proportional (kp),
        .gain_integral     (ki),
        .gain_derivative   (kd),
        .time_step         (dt),
        .inverse_time_step (inv_dt)
    );

    // ------------------------------------------------------------- sequencer
    seq_ctrl_t ctrl;
    logic      seq_ready;
    logic      in_beat;
    logic      out_free;
    logic      m_tvalid_reg;

    assign in_beat  = s_tvalid && seq_ready;
    assign out_free = !m_tvalid_reg || m_tready;

    vfp_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (in_beat),
        .out_free (out_free),
        .ready    (seq_ready),
        .ctrl     (ctrl)
    );

    // ----------------------------------------------------------------- error
    // e0 = setpoint - measured, clipped to the data range
    logic signed [DATA_WIDTH-1:0] measured;
    logic signed [EW-1:0]         err_wide;
    logic signed [DATA_WIDTH-1:0] err_sat;
    logic                         err_clip;

    assign measured = signed'(s_tdata[DATA_WIDTH-1:0]);
    assign err_wide = EW'(setpoint) - EW'(measured);

    always_comb begin
        err_clip = 1'b0;
        err_sat  = DATA_WIDTH'(err_wide);
        if (err_wide > EW'(SMAX)) begin
            err_sat  = SMAX;
            err_clip = 1'b1;
        end else if (err_wide < EW'(SMIN)) begin
            err_sat  = SMIN;
            err_clip = 1'b1;
        end
    end

    logic signed [DATA_WIDTH-1:0] e0_reg;
    logic                         e0_clip_reg;

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            e0_reg      <= err_sat;
            e0_clip_reg <= err_clip;
        end
    end

    // ------------------------------------------------------ shared multiplier
    logic signed [DATA_WIDTH-1:0]   mul_a, mul_b;
    logic signed [2*DATA_WIDTH-1:0] prod;
    logic signed [PW-1:0]           prod_sh;

    logic signed [DATA_WIDTH-1:0] ca_reg, cb_reg, cc_reg;
    logic signed [DATA_WIDTH-1:0] e1_reg, e2_reg;

    always_comb begin
        case (ctrl.mul_sel)
            OP_KD_INVDT: begin
                mul_a = kd;
                mul_b = signed'({1'b0, inv_dt});
            end
            OP_KI_DT: begin
                mul_a = ki;
                mul_b = signed'({1'b0, dt});
            end
            OP_CA_E0: begin
                mul_a = ca_reg;
                mul_b = e0_reg;
            end
            OP_CB_E1: begin
                mul_a = cb_reg;
                mul_b = e1_reg;
            end
            OP_CC_E2: begin
                mul_a = cc_reg;
                mul_b = e2_reg;
            end
            default: begin
                mul_a = kd;
                mul_b = signed'({1'b0, inv_dt});
            end
        endcase
    end

    vfp_mul #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mul (
        .aclk   (aclk),
        .mul_en (ctrl.mul_en),
        .mul_a  (mul_a),
        .mul_b  (mul_b),
        .prod   (prod)
    );

    // floor the product: drop the fractional bits
    assign prod_sh = signed'(prod[2*DATA_WIDTH-1:FRAC_BITS]);

    // ---------------------------------------------------------- coefficients
    logic signed [PW-1:0]         kdi_reg;
    logic signed [CW-1:0]         ca_wide, cb_wide, cc_wide;
    logic signed [DATA_WIDTH-1:0] ca_sat, cb_sat, cc_sat;

    // a = kp + kd*inv_dt + ki*dt ; b = -kp - 2*kd*inv_dt ; c = kd*inv_dt
    assign ca_wide = CW'(kp) + CW'(kdi_reg) + CW'(prod_sh);
    assign cb_wide = -CW'(kp) - (CW'(kdi_reg) <<< 1);
    assign cc_wide = CW'(kdi_reg);

    always_comb begin
        ca_sat = DATA_WIDTH'(ca_wide);
        if (ca_wide > CW'(SMAX))      ca_sat = SMAX;
        else if (ca_wide < CW'(SMIN)) ca_sat = SMIN;

        cb_sat = DATA_WIDTH'(cb_wide);
        if (cb_wide > CW'(SMAX))      cb_sat = SMAX;
        else if (cb_wide < CW'(SMIN)) cb_sat = SMIN;

        cc_sat = DATA_WIDTH'(cc_wide);
        if (cc_wide > CW'(SMAX))      cc_sat = SMAX;
        else if (cc_wide < CW'(SMIN)) cc_sat = SMIN;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld_kdi) begin
            kdi_reg <= prod_sh;
        end
        if (ctrl.ld_coef) begin
            ca_reg <= ca_sat;
            cb_reg <= cb_sat;
            cc_reg <= cc_sat;
        end
    end

    // ----------------------------------------------------- delta and update
    logic signed [CW-1:0]         acc_reg;
    logic signed [CW:0]           u_wide;
    logic signed [DATA_WIDTH-1:0] u_sat;
    logic                         u_clip;
    logic signed [DATA_WIDTH-1:0] ctl_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.acc_first) begin
            acc_reg <= CW'(prod_sh);
        end else if (ctrl.acc_add) begin
            acc_reg <= acc_reg + CW'(prod_sh);
        end
    end

    // the last term (c*e2) is folded in here, straight from the multiplier
    assign u_wide = (CW+1)'(ctl_reg) + (CW+1)'(acc_reg) + (CW+1)'(prod_sh);

    always_comb begin
        u_clip = 1'b0;
        u_sat  = DATA_WIDTH'(u_wide);
        if (u_wide > (CW+1)'(SMAX)) begin
            u_sat  = SMAX;
            u_clip = 1'b1;
        end else if (u_wide < (CW+1)'(SMIN)) begin
            u_sat  = SMIN;
            u_clip = 1'b1;
        end
    end

    // controller state: control value and two past errors
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
            e1_reg  <= '0;
            e2_reg  <= '0;
        end else if (ctrl.finish) begin
            ctl_reg <= u_sat;
            e1_reg  <= e0_reg;
            e2_reg  <= e1_reg;
        end
    end

    // ------------------------------------------------------- output register
    logic [DATA_WIDTH-1:0] out_data_reg;
    logic                  out_sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.finish) begin
            out_data_reg <= unsigned'(u_sat);
            out_sat_reg  <= e0_clip_reg | u_clip;
        end
    end

    assign s_tready = seq_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(out_data_reg);
    assign m_tuser  = out_sat_reg;

endmodule

`default_nettype wire

[design/vfp_checker.sv]
// ============================================================================
// vfp_checker
// Port-level checks on the PID block's stream handshakes and sequencing.
// ============================================================================
`default_nettype none

`include "velocity_form_pid_macros.svh"

module vfp_checker #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [((DATA_WIDTH+7)/8)*8-1:0]  m_tdata,
    input wire logic                             m_tuser
);

    // a stalled result beat holds its payload
    `VFP_ASSERT_RST(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    // a sample closes the input until its result is formed
    `VFP_ASSERT_RST(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "input taken while busy")

    // a new result only follows a busy cycle
    `VFP_ASSERT_RST(a_result_after_work, $rose(m_tvalid) |-> !$past(s_tready), "result appeared without work")

    // reset leaves no pending result and an open input
    `VFP_ASSERT_ALWAYS(a_reset_state, !aresetn |=> !m_tvalid && s_tready, "bad state after reset")

endmodule

bind velocity_form_pid vfp_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_vfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the velocity-form PID block. A directed table comes
// first: reset state, clipped errors, ignored register indexes, gain and
// time-step extremes, zero time steps. Random phases with fresh register
// settings follow. Every sample beat is run through a fixed-point model of the
// controller, and each result beat is compared with the oldest prediction.
// ============================================================================

module testbench;
    import vfp_pkg::*;

    localparam int DW  = DATA_WIDTH_DEF;
    localparam int FRAC = FRAC_BITS_DEF;
    localparam int TDW = ((DW + 7) / 8) * 8;

    localparam longint WORD_MAX = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint WORD_MIN = -WORD_MAX - 1;

    // Indexes with no register behind them; writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    localparam int PHASES          = 16;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int HOLD_PHASE      = 2;    // receiver holds off, sender floods
    localparam int BURST_PHASE     = 5;    // sender never pauses
    localparam int HOLD_CYCLES     = 300;
    localparam int TAIL_CYCLES     = 24;   // longer than a sample takes to pass through the block
    localparam int MAX_REPORTS     = 10;
    localparam int RUN_LIMIT_NS    = 1_500_000;

    typedef struct packed {
        logic [DW-1:0] control;
        logic          clipped;
    } pid_result_t;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    // One line of the directed plan. Sample rows ignore index; typed rows
    // carry a result that is obvious from the register state.
    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_INDEX_W-1:0]  index;
        logic [DW-1:0]           value;
        logic                    typed;
        logic [DW-1:0]           control;
        logic                    clipped;
    } plan_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DW-1:0]          cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDW-1:0]         s_tdata;    // [DW-1:0] measured
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDW-1:0]         m_tdata;    // [DW-1:0] control_out
    logic                   m_tuser;    // [0] saturated

    // Register mirror and controller state of the predictor
    logic [DW-1:0] set_pt;
    logic [DW-1:0] kp_gain;
    logic [DW-1:0] ki_gain;
    logic [DW-1:0] kd_gain;
    logic [DW-2:0] dt_step;
    logic [DW-2:0] dt_inverse;
    longint        ctl_acc;
    longint        err_z1;
    longint        err_z2;

    pid_result_t control_q[$];    // predicted result beats, oldest first
    int          fault_count;
    int          result_count;
    bit          hold_req;

    plan_row_t plan [42] = '{
        // reset state: zero gains keep the output at zero
        '{ROW_SAMPLE, REG_SETPOINT,      32'h0000_0000, 1'b1, 32'h0, 1'b0},
        // error of +2^31 clips
        '{ROW_SAMPLE, REG_SETPOINT,      32'h8000_0000, 1'b1, 32'h0, 1'b1},
        '{ROW_SAMPLE, REG_SETPOINT,      32'h7FFF_FFFF, 1'b1, 32'h0, 1'b0},
        // most negative setpoint: error below -2^31 clips
        '{ROW_WRITE,  REG_SETPOINT,      32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, REG_SETPOINT,      32'h0000_0001, 1'b1, 32'h0, 1'b1},
        // unmapped indexes: setpoint and gains must stay as they are
        '{ROW_WRITE,  REG_UNMAPPED_LO,   32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_UNMAPPED_HI,   32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, REG_SETPOINT,      32'h8000_0000, 1'b1, 32'h0, 1'b0},
        // moderate gains; time step written with bit 31 set, which drops
        '{ROW_WRITE,  REG_SETPOINT,      32'h0001_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_GAIN_PROP,     32'h0001_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_GAIN_INTEGRAL, 32'h0000_8000, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_GAIN_DERIV,    32'h0000_4000, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_TIME_STEP,     32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_INV_TIME_STEP, 32'h0002_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, REG_SETPOINT,      32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, REG_SETPOINT,      32'h0000_8000, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, REG_SETPOINT,      32'hFFFF_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, REG_SETPOINT,      32'h0003_0000, 1'b0, 32'h0, 1'b0},
        // largest positive gains and time steps: coefficients and output clip
        '{ROW_WRITE,  REG_GAIN_PROP,     32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_GAIN_INTEGRAL, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_GAIN_DERIV,    32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_TIME_STEP,     32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_INV_TIME_STEP, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_SETPOINT,      32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, REG_SETPOINT,      32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, REG_SETPOINT,      32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, REG_SETPOINT,      32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, REG_SETPOINT,      32'h0000_0000, 1'b0, 32'h0, 1'b0},
        // most negative gains
        '{ROW_WRITE,  REG_GAIN_PROP,     32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_GAIN_INTEGRAL, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_GAIN_DERIV,    32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_SETPOINT,      32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, REG_SETPOINT,      32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, REG_SETPOINT,      32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, REG_SETPOINT,      32'h8000_0000, 1'b0, 32'h0, 1'b0},
        // zero time steps: integral and derivative terms vanish
        '{ROW_WRITE,  REG_TIME_STEP,     32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_INV_TIME_STEP, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_GAIN_PROP,     32'h0001_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_WRITE,  REG_SETPOINT,      32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, REG_SETPOINT,      32'h0001_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, REG_SETPOINT,      32'hFFFF_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_SAMPLE, REG_SETPOINT,      32'h1234_5678, 1'b0, 32'h0, 1'b0}
    };

    velocity_form_pid i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic longint clip_word(input longint x);
        if (x > WORD_MAX) return WORD_MAX;
        if (x < WORD_MIN) return WORD_MIN;
        return x;
    endfunction

    // Exact product, floored back to Q16.16 by the arithmetic shift
    function automatic longint qmul(input longint x, input longint y);
        return (x * y) >>> FRAC;
    endfunction

    // Advance the controller by one measured sample and return its result
    function automatic pid_result_t pid_update(input logic [DW-1:0] sample);
        pid_result_t res;
        longint      kp;
        longint      ki;
        longint      kd;
        longint      err_raw;
        longint      err_now;
        longint      kd_inv;
        longint      ki_dt;
        longint      coef_a;
        longint      coef_b;
        longint      coef_c;
        longint      ctl_raw;
        longint      ctl_next;
        kp = longint'($signed(kp_gain));
        ki = longint'($signed(ki_gain));
        kd = longint'($signed(kd_gain));

        err_raw = longint'($signed(set_pt)) - longint'($signed(sample));
        err_now = clip_word(err_raw);

        // coefficient clipping is silent, it never raises the flag
        kd_inv = qmul(kd, longint'(dt_inverse));
        ki_dt  = qmul(ki, longint'(dt_step));
        coef_a = clip_word(kp + kd_inv + ki_dt);
        coef_b = clip_word(-kp - 2 * kd_inv);
        coef_c = clip_word(kd_inv);

        ctl_raw  = ctl_acc + qmul(coef_a, err_now) + qmul(coef_b, err_z1)
                 + qmul(coef_c, err_z2);
        ctl_next = clip_word(ctl_raw);

        ctl_acc = ctl_next;
        err_z2  = err_z1;
        err_z1  = err_now;

        res.control = ctl_next[DW-1:0];
        res.clipped = (err_raw != err_now) || (ctl_raw != ctl_next);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Random choices
    // ------------------------------------------------------------------------

    // Mostly no pause, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Gains and setpoint: mostly within +-4.0, with extremes and full range
    function automatic logic [DW-1:0] pick_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 15) return 32'h7FFF_FFFF;
        if (r < 20) return 32'h8000_0000;
        if (r < 32) return $urandom;
        return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    endfunction

    // Time steps: zero, tiny, the top value, bit 31 set, and typical periods
    function automatic logic [DW-1:0] pick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return '0;
        if (r < 16) return 32'h0000_0001;
        if (r < 22) return 32'h7FFF_FFFF;
        if (r < 28) return 32'hFFFF_FFFF;
        if (r < 40) return $urandom;
        return 32'($urandom_range(1, 32'h0004_0000));
    endfunction

    // Samples: mostly near the setpoint, so the loop stays out of clipping
    function automatic logic [DW-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return 32'h8000_0000;
        if (r < 16) return 32'h7FFF_FFFF;
        if (r < 20) return '0;
        if (r < 36) return $urandom;
        return set_pt + 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endfunction

    // ------------------------------------------------------------------------
    // Sample side
    // ------------------------------------------------------------------------

    // Drop valid and wait until every predicted beat has come back
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (control_q.size() != 0) @(negedge aclk);
    endtask

    // Registers only change while nothing is in flight
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [DW-1:0] value);
        wait_idle();
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(posedge aclk);
        case (idx)
            REG_SETPOINT:      set_pt     = value;
            REG_GAIN_PROP:     kp_gain    = value;
            REG_GAIN_INTEGRAL: ki_gain    = value;
            REG_GAIN_DERIV:    kd_gain    = value;
            REG_TIME_STEP:     dt_step    = value[DW-2:0];
            REG_INV_TIME_STEP: dt_inverse = value[DW-2:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Offer one sample beat, predict at the accepting edge, then maybe pause
    task automatic send_sample(input logic [DW-1:0] sample, input logic typed,
                               input logic [DW-1:0] typed_ctl,
                               input logic typed_clip, input bit gapless);
        pid_result_t want;
        int          gap;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = sample;
        do @(posedge aclk); while (!s_tready);
        want = pid_update(sample);
        if (typed) begin
            want.control = typed_ctl;
            want.clipped = typed_clip;
        end
        control_q.push_back(want);
        gap = gapless ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: ready pattern and checking
    // ------------------------------------------------------------------------

    initial begin : result_sink
        int run_len;
        int stall_len;
        m_tready = 1'b0;
        @(negedge aclk);
        while (aresetn !== 1'b1) @(negedge aclk);
        forever begin
            // long hold-off on request, so the block fills and stalls s_tready
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            run_len = $urandom_range(1, 40);
            m_tready = 1'b1;
            repeat (run_len) @(negedge aclk);
            stall_len = pick_gap();
            if (stall_len > 0) begin
                m_tready = 1'b0;
                repeat (stall_len) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        pid_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (control_q.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("result beat %0d: control %h sat %b with none predicted",
                             result_count, m_tdata[DW-1:0], m_tuser);
            end else begin
                want = control_q.pop_front();
                if (m_tdata[DW-1:0] !== want.control || m_tuser !== want.clipped) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("result beat %0d: expected control %h sat %b, got %h sat %b",
                                 result_count, want.control, want.clipped,
                                 m_tdata[DW-1:0], m_tuser);
                end
            end
            result_count++;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin : stimulus
        bit gapless;
        // every input known from time zero, with reset asserted
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_SETPOINT;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        hold_req    = 1'b0;
        fault_count = 0;
        result_count = 0;

        // predictor starts from the reset values
        set_pt     = '0;
        kp_gain    = '0;
        ki_gain    = '0;
        kd_gain    = '0;
        dt_step    = 31'h0001_0000;
        dt_inverse = 31'h0001_0000;
        ctl_acc    = 0;
        err_z1     = 0;
        err_z2     = 0;

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // directed table
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE)
                write_reg(plan[i].index, plan[i].value);
            else
                send_sample(plan[i].value, plan[i].typed, plan[i].control,
                            plan[i].clipped, 1'b0);
        end

        // random phases, each under fresh register settings
        for (int phase = 0; phase < PHASES; phase++) begin
            if ($urandom_range(0, 3) != 0) write_reg(REG_SETPOINT, pick_gain());
            if ($urandom_range(0, 3) != 0) write_reg(REG_GAIN_PROP, pick_gain());
            if ($urandom_range(0, 3) != 0) write_reg(REG_GAIN_INTEGRAL, pick_gain());
            if ($urandom_range(0, 3) != 0) write_reg(REG_GAIN_DERIV, pick_gain());
            if ($urandom_range(0, 3) != 0) write_reg(REG_TIME_STEP, pick_step());
            if ($urandom_range(0, 3) != 0) write_reg(REG_INV_TIME_STEP, pick_step());
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
                          $urandom);

            gapless = (phase == HOLD_PHASE) || (phase == BURST_PHASE);
            if (phase == HOLD_PHASE) hold_req = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_sample(pick_sample(), 1'b0, '0, 1'b0, gapless);
        end

        // drain, then give stray beats a chance to show up
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("[velocity_form_pid] OK");
        end else begin
            $display("[velocity_form_pid] ERROR");
        end
        $finish;
    end

    // hard stop in case a beat never arrives
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("[velocity_form_pid] ERROR");
        $finish;
    end

endmodule
